FILE: rtl/atc_pkg.sv
package atc_pkg;

	typedef enum logic [3:0] {
		CLS_LABEL   = 4'd0,
		CLS_COMMENT = 4'd1,
		CLS_REG     = 4'd2,
		CLS_DEC     = 4'd3,
		CLS_HEX     = 4'd4,
		CLS_BIN     = 4'd5,
		CLS_OCT     = 4'd6,
		CLS_STRING  = 4'd7,
		CLS_INSTR   = 4'd8,
		CLS_IDENT   = 4'd9,
		CLS_OFFSET  = 4'd10,
		CLS_UNREC   = 4'd11,
		CLS_EMPTY   = 4'd12
	} cls_t;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_O  = 8'h6F;

	localparam int HEAD_LEN     = 5;
	localparam int CNT_W        = 3;
	localparam int MN_TABLE_LEN = 37;
	localparam int MN_IDX_W     = 6;

	// class flag bits
	localparam int FL_ALL_DIG  = 0;
	localparam int FL_DIG_1    = 1;
	localparam int FL_HEX_2    = 2;
	localparam int FL_HEX_3    = 3;
	localparam int FL_ALNUM    = 4;
	localparam int FL_W        = 5;

	typedef logic [HEAD_LEN-1:0][7:0] head_t;

	// state of a finished token, handed from scan to classify
	typedef struct packed {
		logic             empty;
		logic [7:0]       last_char;
		logic [CNT_W-1:0] count;
		head_t            head;
		logic [FL_W-1:0]  flags;
		logic             offset_ok;
		logic             close_seen;
	} snap_t;

	// mnemonics, first character in the top byte, zero padded
	localparam logic [8*HEAD_LEN-1:0] MN_TABLE [MN_TABLE_LEN] = '{
		{"nop", 16'h0}, {"jmp", 16'h0}, {"llo", 16'h0}, {"lhi", 16'h0},
		{"lw", 24'h0}, {"sw", 24'h0}, {"beq", 16'h0}, {"bne", 16'h0},
		{"and", 16'h0}, {"or", 24'h0}, {"xor", 16'h0}, {"slt", 16'h0},
		{"uadd", 8'h0}, {"sadd", 8'h0}, {"ssub", 8'h0}, {"usub", 8'h0},
		{"blt", 16'h0}, {"bgt", 16'h0}, {"bge", 16'h0}, {"ble", 16'h0},
		{"inc", 16'h0}, {"dec", 16'h0}, {"mul", 16'h0}, {"div", 16'h0},
		{"sll", 16'h0}, {"srl", 16'h0}, {"push", 8'h0}, {"pop", 16'h0},
		{"not", 16'h0}, {"rem", 16'h0}, "clear", {"out", 16'h0},
		{"load", 8'h0}, {"call", 8'h0}, {"ret", 16'h0}, {"wait", 8'h0},
		{"in", 24'h0}
	};

endpackage

FILE: rtl/atc_if.sv
interface atc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       token_end;
	logic       empty_token;

	modport source (output valid, char_code, token_end, empty_token, input ready);
	modport sink (input valid, char_code, token_end, empty_token, output ready);
endinterface

interface atc_class_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_class;
	logic [5:0] mnemonic_index;
	logic       is_error;

	modport source (output valid, token_class, mnemonic_index, is_error, input ready);
	modport sink (input valid, token_class, mnemonic_index, is_error, output ready);
endinterface

FILE: rtl/atc_scan.sv
module atc_scan
	import atc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	atc_char_if.sink   chars,
	input  logic       down_ready,
	output logic       snap_valid_s1,
	output snap_t      snap_s1
);

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_DOLLAR,
		PH_LOWER,
		PH_CLEAN,
		PH_DIRTY
	} phase_t;

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_low(input logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic logic is_hexl(input logic [7:0] c);
		return is_dig(c) || (c >= "a" && c <= "f");
	endfunction

	logic [CNT_W-1:0] cnt_q, cnt_d;
	head_t            head_q, head_d;
	logic [FL_W-1:0]  flags_q, flags_d;
	phase_t           ph_q, ph_d;
	logic             ok_q, ok_d;
	logic             close_q, close_d;
	logic             xfer, done;
	logic [7:0]       c;
	logic             aln;

	assign chars.ready = !snap_valid_s1 || down_ready;
	assign xfer = chars.valid && chars.ready;
	assign done = chars.token_end || chars.empty_token;
	assign c    = chars.char_code;
	assign aln  = is_dig(c) || is_low(c);

	// token state after this character
	always_comb begin
		head_d  = head_q;
		flags_d = flags_q;
		ph_d    = ph_q;
		ok_d    = ok_q;
		close_d = close_q;
		cnt_d   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

		for (int k = 0; k < HEAD_LEN; k++) begin
			if (cnt_q == CNT_W'(k)) begin
				head_d[k] = c;
			end
		end

		if (!is_dig(c)) flags_d[FL_ALL_DIG] = 1'b0;
		if (cnt_q >= 3'd1 && !is_dig(c)) flags_d[FL_DIG_1] = 1'b0;
		if (cnt_q >= 3'd2 && !is_hexl(c)) flags_d[FL_HEX_2] = 1'b0;
		if (cnt_q >= 3'd3 && !is_hexl(c)) flags_d[FL_HEX_3] = 1'b0;
		if (!aln) flags_d[FL_ALNUM] = 1'b0;

		case (ph_q)
			PH_OPEN: begin
				if (c == CH_LPAREN || c == CH_LBRACK) ph_d = PH_DOLLAR;
			end
			PH_DOLLAR: begin
				if (c != CH_DOLLAR) ok_d = 1'b0;
				ph_d = PH_LOWER;
			end
			PH_LOWER: begin
				if (!is_low(c)) ok_d = 1'b0;
				ph_d = PH_CLEAN;
			end
			PH_CLEAN, PH_DIRTY: begin
				if (c == CH_RPAREN || c == CH_RBRACK) begin
					if (ph_q != PH_CLEAN) ok_d = 1'b0;
					close_d = 1'b1;
					ph_d    = PH_DIRTY;
				end else if (!aln) begin
					ph_d = PH_DIRTY;
				end
			end
			default: begin
				ph_d = PH_OPEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			head_q        <= '0;
			flags_q       <= '1;
			ph_q          <= PH_OPEN;
			ok_q          <= 1'b1;
			close_q       <= 1'b0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (xfer) begin
				if (done) begin
					cnt_q   <= '0;
					head_q  <= '0;
					flags_q <= '1;
					ph_q    <= PH_OPEN;
					ok_q    <= 1'b1;
					close_q <= 1'b0;
				end else begin
					cnt_q   <= cnt_d;
					head_q  <= head_d;
					flags_q <= flags_d;
					ph_q    <= ph_d;
					ok_q    <= ok_d;
					close_q <= close_d;
				end
			end
			if (xfer && done) begin
				snap_valid_s1 <= 1'b1;
			end else if (down_ready) begin
				snap_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && done) begin
			snap_s1.empty      <= chars.empty_token;
			snap_s1.last_char  <= c;
			snap_s1.count      <= cnt_d;
			snap_s1.head       <= head_d;
			snap_s1.flags      <= flags_d;
			snap_s1.offset_ok  <= ok_d;
			snap_s1.close_seen <= close_d;
		end
	end

endmodule

FILE: rtl/atc_judge.sv
module atc_judge
	import atc_pkg::*;
#(
	parameter int MNEMONIC_COUNT = 37
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        snap_valid_s1,
	input  snap_t       snap_s1,
	output logic        up_ready,
	atc_class_if.source classes
);

	logic                [8*HEAD_LEN-1:0] word;
	logic                hit;
	logic [MN_IDX_W-1:0] hit_idx;
	logic                neg;
	logic [7:0]          zchar, pchar;
	logic                body_ok, len_ok;
	logic [CNT_W-1:0]    n;
	logic [7:0]          h0, lc;
	logic [FL_W-1:0]     f;
	cls_t                pfx, cls;
	logic [MN_IDX_W-1:0] idx;
	logic                valid_q;
	logic                load;

	assign n  = snap_s1.count;
	assign h0 = snap_s1.head[0];
	assign lc = snap_s1.last_char;
	assign f  = snap_s1.flags;
	assign word = {snap_s1.head[0], snap_s1.head[1], snap_s1.head[2],
		snap_s1.head[3], snap_s1.head[4]};

	// first matching table entry wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = MN_TABLE_LEN - 1; i >= 0; i--) begin
			if (i < MNEMONIC_COUNT && word == MN_TABLE[i]) begin
				hit     = 1'b1;
				hit_idx = MN_IDX_W'(i);
			end
		end
	end

	// 0x / 0b / 0o, optionally after a minus
	always_comb begin
		neg     = (h0 == CH_MINUS);
		zchar   = neg ? snap_s1.head[1] : snap_s1.head[0];
		pchar   = neg ? snap_s1.head[2] : snap_s1.head[1];
		body_ok = neg ? f[FL_HEX_3] : f[FL_HEX_2];
		len_ok  = neg ? (n >= 3'd4) : (n >= 3'd3);
		pfx     = CLS_LABEL;
		if (len_ok && zchar == CH_ZERO && body_ok) begin
			case (pchar)
				CH_LOW_X: pfx = CLS_HEX;
				CH_LOW_B: pfx = CLS_BIN;
				CH_LOW_O: pfx = CLS_OCT;
				default:  pfx = CLS_LABEL;
			endcase
		end
	end

	always_comb begin
		idx = '0;
		if (snap_s1.empty) begin
			cls = CLS_EMPTY;
		end else if (n >= 3'd2 && lc == CH_COLON) begin
			cls = CLS_LABEL;
		end else if (h0 == CH_HASH) begin
			cls = CLS_COMMENT;
		end else if (h0 == CH_DOLLAR) begin
			cls = CLS_REG;
		end else if (f[FL_ALL_DIG] || (neg && f[FL_DIG_1])) begin
			cls = CLS_DEC;
		end else if (pfx != CLS_LABEL) begin
			cls = pfx;
		end else if (n >= 3'd2 && h0 == CH_QUOTE && lc == CH_QUOTE) begin
			cls = CLS_STRING;
		end else if (f[FL_ALNUM]) begin
			if (hit && n <= 3'(HEAD_LEN)) begin
				cls = CLS_INSTR;
				idx = hit_idx;
			end else begin
				cls = CLS_IDENT;
			end
		end else if (n >= 3'(HEAD_LEN) && snap_s1.offset_ok && snap_s1.close_seen) begin
			cls = CLS_OFFSET;
		end else begin
			cls = CLS_UNREC;
		end
	end

	assign up_ready      = !valid_q || classes.ready;
	assign load          = snap_valid_s1 && up_ready;
	assign classes.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (classes.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			classes.token_class    <= cls;
			classes.mnemonic_index <= idx;
			classes.is_error       <= (cls inside {CLS_STRING, CLS_UNREC, CLS_EMPTY});
		end
	end

endmodule

FILE: rtl/assembler_token_classifier.sv
// Channel   Modport  Payload                                  Transfer
// chars     sink     char_code[8] token_end empty_token       valid & ready
// classes   source   token_class[4] mnemonic_index[6] is_error valid & ready
//
// One character per cycle while chars is ready, back to back, with no gaps
// between tokens. A result passes through the token snapshot and then the
// classify result register after the transfer of the token's last character
// (or of an empty marker). Snapshot and result register give two slots;
// chars stalls only when both hold a result and classes is not ready.
// Characters that do not close a token never stall while the snapshot slot
// can drain. arst_n clears the running token state and both valid bits.
module assembler_token_classifier
	import atc_pkg::*;
#(
	parameter int MNEMONIC_COUNT = 37
) (
	input logic         clk,
	input logic         arst_n,
	atc_char_if.sink    chars,
	atc_class_if.source classes
);

	// stage between scan and classify
	logic  snap_valid_s1;
	snap_t snap_s1;
	logic  judge_ready;

	// running flags, offset tracker, first five characters
	atc_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.down_ready    (judge_ready),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1)
	);

	// priority classification and mnemonic lookup into the result register
	atc_judge #(
		.MNEMONIC_COUNT (MNEMONIC_COUNT)
	) u_judge (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.up_ready      (judge_ready),
		.classes       (classes)
	);

	// error flag follows the class
	a_err_class: assert property (@(posedge clk) disable iff (!arst_n)
		classes.valid |-> (classes.is_error ==
			(classes.token_class == CLS_STRING || classes.token_class == CLS_UNREC ||
			 classes.token_class == CLS_EMPTY)))
		else $error("is_error does not match token_class");

	// index only for instructions, and inside the searched range
	a_idx_class: assert property (@(posedge clk) disable iff (!arst_n)
		(classes.valid && classes.token_class != CLS_INSTR) |->
			classes.mnemonic_index == '0)
		else $error("mnemonic_index set on a non-instruction");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(classes.valid && classes.token_class == CLS_INSTR) |->
			(32'(classes.mnemonic_index) < MNEMONIC_COUNT))
		else $error("mnemonic_index beyond table");

	// an empty marker lands in the snapshot on the next cycle
	a_empty_snap: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && chars.empty_token) |=>
			(snap_valid_s1 && snap_s1.empty))
		else $error("empty token not captured");

endmodule
